FILE: hw/rtl/crc8_checked_word_deframer_unit_assert.svh
// Assertion macros shared by the CRC-8 word deframer RTL.
`ifndef CRC8_CHECKED_WORD_DEFRAMER_UNIT_ASSERT_SVH
`define CRC8_CHECKED_WORD_DEFRAMER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CWD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CWD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/cwd_pkg.sv
// Package with types, codes and the CRC-8 byte update for the word deframer.
`timescale 1ns / 1ps

package cwd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;

  localparam logic [ByteW-1:0] CrcPolyReset = 8'h31;
  localparam logic [ByteW-1:0] CrcInitReset = 8'hFF;

  localparam logic CFG_CRC_POLYNOMIAL = 1'b0;
  localparam logic CFG_CRC_INITIAL    = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK           = 2'd0,
    STATUS_CRC_MISMATCH = 2'd1,
    STATUS_SHORT_READ   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    POS_HIGH = 2'd0,
    POS_LOW  = 2'd1,
    POS_CRC  = 2'd2
  } pos_e;

  typedef struct packed {
    logic [ByteW-1:0] crc_poly;
    logic [ByteW-1:0] crc_init;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] reply_byte;
    logic             end_of_read;
  } in_item_t;

  // One byte through the CRC, MSB first, top bit of the polynomial implied.
  function automatic logic [ByteW-1:0] crc_feed(input logic [ByteW-1:0] crc,
                                                input logic [ByteW-1:0] data,
                                                input logic [ByteW-1:0] poly);
    logic [ByteW-1:0] c;
    c = crc ^ data;
    for (int k = 0; k < ByteW; k++) begin
      if (c[ByteW-1]) begin
        c = {c[ByteW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[ByteW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: hw/rtl/cwd_stream_if.sv
// Valid/ready channel interfaces for reply bytes in and checked words out.
`timescale 1ns / 1ps

interface cwd_in_if;
  logic                       valid;
  logic                       ready;
  logic [cwd_pkg::ByteW-1:0]  reply_byte;
  logic                       end_of_read;

  modport source (output valid, output reply_byte, output end_of_read, input ready);
  modport sink   (input valid, input reply_byte, input end_of_read, output ready);
endinterface

interface cwd_out_if;
  logic                       valid;
  logic                       ready;
  logic [cwd_pkg::WordW-1:0]  word_value;
  cwd_pkg::status_e           status;
  logic                       read_failed;
  logic                       last_of_read;

  modport source (output valid, output word_value, output status, output read_failed,
                  output last_of_read, input ready);
  modport sink   (input valid, input word_value, input status, input read_failed,
                  input last_of_read, output ready);
endinterface

FILE: hw/rtl/cwd_cfg_regs.sv
// Configuration registers: CRC polynomial and CRC start value.
`timescale 1ns / 1ps

module cwd_cfg_regs (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [cwd_pkg::ByteW-1:0] cfg_wdata_i,
  output cwd_pkg::cfg_t             cfg_o
);

  cwd_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        cwd_pkg::CFG_CRC_POLYNOMIAL: cfg_d.crc_poly = cfg_wdata_i;
        cwd_pkg::CFG_CRC_INITIAL:    cfg_d.crc_init = cfg_wdata_i;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.crc_poly <= cwd_pkg::CrcPolyReset;
      cfg_q.crc_init <= cwd_pkg::CrcInitReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/cwd_in_stage.sv
// Input register stage for reply bytes.
`timescale 1ns / 1ps

module cwd_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  cwd_in_if.sink            in_ch,
  input  logic              pop_i,
  output logic              valid_o,
  output cwd_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  cwd_pkg::in_item_t item_q, item_d;
  logic              take;

  assign in_ch.ready = !valid_q || pop_i;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (take) begin
      valid_d            = 1'b1;
      item_d.reply_byte  = in_ch.reply_byte;
      item_d.end_of_read = in_ch.end_of_read;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: hw/rtl/cwd_core.sv
// Group tracking, CRC update and result register of the word deframer.
`timescale 1ns / 1ps

module cwd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cwd_pkg::cfg_t     cfg_i,
  input  logic              valid_i,
  input  cwd_pkg::in_item_t item_i,
  output logic              pop_o,
  cwd_out_if.source         out_ch
);

  cwd_pkg::pos_e             pos_q, pos_d;
  logic [cwd_pkg::ByteW-1:0] high_q, high_d;
  logic [cwd_pkg::ByteW-1:0] low_q, low_d;
  logic [cwd_pkg::ByteW-1:0] crc_q, crc_d;
  logic                      failed_q, failed_d;

  logic                      out_valid_q, out_valid_d;
  logic [cwd_pkg::WordW-1:0] word_q, word_d;
  cwd_pkg::status_e          status_q, status_d;
  logic                      rfail_q, rfail_d;
  logic                      last_q, last_d;

  logic                      fire;
  logic                      bad;
  logic                      has_res;
  logic [cwd_pkg::ByteW-1:0] crc_base;
  logic [cwd_pkg::ByteW-1:0] crc_new;

  assign fire     = valid_i && (!out_valid_q || out_ch.ready);
  assign pop_o    = fire;
  assign crc_base = (pos_q == cwd_pkg::POS_HIGH) ? cfg_i.crc_init : crc_q;
  assign crc_new  = cwd_pkg::crc_feed(crc_base, item_i.reply_byte, cfg_i.crc_poly);
  assign bad      = (crc_q != item_i.reply_byte);

  // Next state
  always_comb begin
    pos_d    = pos_q;
    high_d   = high_q;
    low_d    = low_q;
    crc_d    = crc_q;
    failed_d = failed_q;
    if (fire) begin
      unique case (pos_q)
        cwd_pkg::POS_HIGH: begin
          high_d   = item_i.reply_byte;
          crc_d    = crc_new;
          pos_d    = item_i.end_of_read ? cwd_pkg::POS_HIGH : cwd_pkg::POS_LOW;
          failed_d = item_i.end_of_read ? 1'b0 : failed_q;
        end
        cwd_pkg::POS_LOW: begin
          low_d    = item_i.reply_byte;
          crc_d    = crc_new;
          pos_d    = item_i.end_of_read ? cwd_pkg::POS_HIGH : cwd_pkg::POS_CRC;
          failed_d = item_i.end_of_read ? 1'b0 : failed_q;
        end
        default: begin
          pos_d    = cwd_pkg::POS_HIGH;
          failed_d = item_i.end_of_read ? 1'b0 : (failed_q | bad);
        end
      endcase
    end
  end

  // Result
  always_comb begin
    has_res  = item_i.end_of_read || (pos_q == cwd_pkg::POS_CRC);
    word_d   = word_q;
    status_d = status_q;
    rfail_d  = rfail_q;
    last_d   = last_q;
    if (fire && has_res) begin
      last_d = item_i.end_of_read;
      if (pos_q == cwd_pkg::POS_CRC) begin
        word_d   = {high_q, low_q};
        status_d = bad ? cwd_pkg::STATUS_CRC_MISMATCH : cwd_pkg::STATUS_OK;
        rfail_d  = failed_q | bad;
      end else begin
        word_d   = '0;
        status_d = cwd_pkg::STATUS_SHORT_READ;
        rfail_d  = 1'b1;
      end
    end
    if (fire) begin
      out_valid_d = has_res;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= cwd_pkg::POS_HIGH;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    high_q   <= high_d;
    low_q    <= low_d;
    crc_q    <= crc_d;
    word_q   <= word_d;
    status_q <= status_d;
    rfail_q  <= rfail_d;
    last_q   <= last_d;
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.word_value   = word_q;
  assign out_ch.status       = status_q;
  assign out_ch.read_failed  = rfail_q;
  assign out_ch.last_of_read = last_q;

endmodule

FILE: hw/rtl/crc8_checked_word_deframer_unit.sv
// Top level of the CRC-8 checked word deframer.
`timescale 1ns / 1ps
`include "crc8_checked_word_deframer_unit_assert.svh"

// Takes reply bytes one per transfer in groups of high byte, low byte, CRC-8
// and gives one checked 16-bit word per group, or a short-read result when
// end_of_read comes inside a group. One byte is accepted every cycle unless
// the output stalls: each byte passes through the input register, then the
// unrolled 8-step CRC update and group tracking load the result register.
// The result register frees as its transfer completes, and input stalls only
// while both registers hold an item. The user must write the CRC polynomial
// (index 0) and start value (index 1) only while idle; it is not enforced.
module crc8_checked_word_deframer_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [cwd_pkg::ByteW-1:0] cfg_wdata_i,
  cwd_in_if.sink                    in_ch,
  cwd_out_if.source                 out_ch
);

  cwd_pkg::cfg_t     cfg;
  logic              s1_valid;
  cwd_pkg::in_item_t s1_item;
  logic              s1_pop;

  cwd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cwd_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .pop_i   (s1_pop),
    .valid_o (s1_valid),
    .item_o  (s1_item)
  );

  cwd_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (s1_valid),
    .item_i  (s1_item),
    .pop_o   (s1_pop),
    .out_ch  (out_ch)
  );

  `CWD_ASSERT_IMPL(a_short_read_fields, clk_i, rst_ni,
    out_ch.valid && (out_ch.status == cwd_pkg::STATUS_SHORT_READ),
    out_ch.read_failed && out_ch.last_of_read && (out_ch.word_value == '0),
    "short-read result with bad fields")
  `CWD_ASSERT_IMPL(a_mismatch_fails_read, clk_i, rst_ni,
    out_ch.valid && (out_ch.status == cwd_pkg::STATUS_CRC_MISMATCH),
    out_ch.read_failed, "crc mismatch without read_failed")
  `CWD_ASSERT_IMPL(a_full_blocks_input, clk_i, rst_ni,
    s1_valid && out_ch.valid && !out_ch.ready, !in_ch.ready,
    "input accepted while both stages are held")
  `CWD_ASSERT_NEXT(a_pop_frees_stage, clk_i, rst_ni,
    s1_pop && !(in_ch.valid && in_ch.ready), !s1_valid,
    "input stage still full after its item moved on")

endmodule
